// ----- rtl/cpss_pkg.sv -----
// ---------------------------------------------------------------------------
// cpss_pkg
// Types, codes and helpers shared by the page stream statistics block.
// ---------------------------------------------------------------------------
package cpss_pkg;

  typedef enum logic [1:0] {
    ST_EXISTING = 2'd0,
    ST_NEW      = 2'd1,
    ST_FULL     = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_UPD,
    S_ALLOC,
    S_FULL
  } state_t;

  typedef struct packed {
    logic [31:0] pages;
    logic [15:0] min_bytes;
    logic [15:0] max_bytes;
    logic [7:0]  min_packets;
    logic [7:0]  max_packets;
    logic [31:0] packet_sum;
    logic [47:0] byte_sum;
    logic [47:0] payload_sum;
  } stats_t;

  typedef struct packed {
    status_t     status;
    logic [3:0]  stream_index;
    logic [7:0]  full_packets;
    logic [1:0]  partial_packets;
    stats_t      stats;
  } res_t;

  typedef struct packed {
    logic [7:0] full_packets;
    logic [1:0] partial_packets;
  } split_t;

  function automatic split_t packet_split(input logic [7:0] npk, input logic cont,
                                          input logic trunc);
    split_t     s;
    logic [1:0] edges;
    edges = {1'b0, cont} + {1'b0, trunc};
    s = '0;
    if (npk == 8'd1) begin
      if (cont | trunc) s.partial_packets = 2'd1;
      else s.full_packets = 8'd1;
    end else if (npk >= 8'd2) begin
      s.partial_packets = edges;
      s.full_packets    = npk - {6'd0, edges};
    end
    return s;
  endfunction

endpackage

// ----- rtl/cpss_ram.sv -----
// ---------------------------------------------------------------------------
// cpss_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module cpss_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

endmodule

// ----- rtl/cpss_engine.sv -----
// ---------------------------------------------------------------------------
// cpss_engine
// Serial scan over the stream table and read-modify-write of one entry.
// ---------------------------------------------------------------------------
module cpss_engine #(
  parameter int MAX_STREAMS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [31:0]       serial_no,
  input  logic [7:0]        packet_count,
  input  logic [15:0]       page_bytes,
  input  logic [15:0]       payload_bytes,
  input  logic              first_continues,
  input  logic              last_truncated,
  input  logic              res_free,
  output logic              res_load,
  output cpss_pkg::res_t    res
);
  import cpss_pkg::*;

  localparam int IW = (MAX_STREAMS > 1) ? $clog2(MAX_STREAMS) : 1;
  localparam int CW = $clog2(MAX_STREAMS + 1);

  state_t        state, state_next;
  logic [CW-1:0] used;
  logic [CW-1:0] scan_cnt;
  logic          chk;
  logic [IW-1:0] chk_idx;
  logic [31:0]   serial_q;
  logic [7:0]    npk_q;
  logic [15:0]   pb_q;
  logic [15:0]   db_q;
  split_t        split_q;

  logic [31:0]   ser_rdata;
  stats_t        st_rdata;
  stats_t        st_wdata;
  stats_t        upd;
  stats_t        fresh;
  logic          match;
  logic          issue;
  logic          accept;
  logic          tbl_full;
  logic          ser_we;
  logic          st_we;
  logic [IW-1:0] st_waddr;
  logic [IW-1:0] res_idx;
  logic [IW+3:0] idx_ext;
  logic [32:0]   pkt_sum_w;
  logic [48:0]   byte_sum_w;
  logic [48:0]   pay_sum_w;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state != S_IDLE);
  assign match    = (state == S_SCAN) && chk && (ser_rdata == serial_q);
  assign issue    = (state == S_SCAN) && !match && (scan_cnt < used);
  assign tbl_full = (used == CW'(MAX_STREAMS));

  cpss_ram #(.WIDTH(32), .DEPTH(MAX_STREAMS)) u_serial_ram (
    .clk   (clk),
    .we    (ser_we),
    .waddr (used[IW-1:0]),
    .wdata (serial_q),
    .re    (issue),
    .raddr (scan_cnt[IW-1:0]),
    .rdata (ser_rdata)
  );

  cpss_ram #(.WIDTH($bits(stats_t)), .DEPTH(MAX_STREAMS)) u_stats_ram (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .re    (issue),
    .raddr (scan_cnt[IW-1:0]),
    .rdata (st_rdata)
  );

  always_comb begin
    pkt_sum_w  = {1'b0, st_rdata.packet_sum} + {25'd0, npk_q};
    byte_sum_w = {1'b0, st_rdata.byte_sum} + {33'd0, pb_q};
    pay_sum_w  = {1'b0, st_rdata.payload_sum} + {33'd0, db_q};
    upd.pages       = (&st_rdata.pages) ? st_rdata.pages : st_rdata.pages + 32'd1;
    upd.min_bytes   = (pb_q < st_rdata.min_bytes) ? pb_q : st_rdata.min_bytes;
    upd.max_bytes   = (pb_q > st_rdata.max_bytes) ? pb_q : st_rdata.max_bytes;
    upd.min_packets = (npk_q < st_rdata.min_packets) ? npk_q : st_rdata.min_packets;
    upd.max_packets = (npk_q > st_rdata.max_packets) ? npk_q : st_rdata.max_packets;
    upd.packet_sum  = pkt_sum_w[32] ? '1 : pkt_sum_w[31:0];
    upd.byte_sum    = byte_sum_w[48] ? '1 : byte_sum_w[47:0];
    upd.payload_sum = pay_sum_w[48] ? '1 : pay_sum_w[47:0];

    fresh.pages       = 32'd1;
    fresh.min_bytes   = pb_q;
    fresh.max_bytes   = pb_q;
    fresh.min_packets = npk_q;
    fresh.max_packets = npk_q;
    fresh.packet_sum  = {24'd0, npk_q};
    fresh.byte_sum    = {32'd0, pb_q};
    fresh.payload_sum = {32'd0, db_q};
  end

  always_comb begin
    state_next = state;
    res_load   = 1'b0;
    ser_we     = 1'b0;
    st_we      = 1'b0;
    st_waddr   = chk_idx;
    st_wdata   = upd;
    res_idx    = chk_idx;
    res.status = ST_EXISTING;
    res.stats  = upd;
    case (state)
      S_IDLE: begin
        if (accept) state_next = S_SCAN;
      end
      S_SCAN: begin
        if (match) state_next = S_UPD;
        else if (!issue) state_next = tbl_full ? S_FULL : S_ALLOC;
      end
      S_UPD: begin
        if (res_free) begin
          res_load   = 1'b1;
          st_we      = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_ALLOC: begin
        res.status = ST_NEW;
        res.stats  = fresh;
        st_waddr   = used[IW-1:0];
        st_wdata   = fresh;
        res_idx    = used[IW-1:0];
        if (res_free) begin
          res_load   = 1'b1;
          ser_we     = 1'b1;
          st_we      = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_FULL: begin
        res.status = ST_FULL;
        res.stats  = '0;
        res_idx    = '0;
        if (res_free) begin
          res_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
    idx_ext             = {4'd0, res_idx};
    res.stream_index    = idx_ext[3:0];
    res.full_packets    = split_q.full_packets;
    res.partial_packets = split_q.partial_packets;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      used  <= '0;
      chk   <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_ALLOC && res_free) used <= used + CW'(1);
      if (accept) chk <= 1'b0;
      else if (state == S_SCAN && !match) chk <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      serial_q <= serial_no;
      npk_q    <= packet_count;
      pb_q     <= page_bytes;
      db_q     <= payload_bytes;
      split_q  <= packet_split(packet_count, first_continues, last_truncated);
      scan_cnt <= '0;
    end else if (issue) begin
      scan_cnt <= scan_cnt + CW'(1);
      chk_idx  <= scan_cnt[IW-1:0];
    end
  end

endmodule

// ----- rtl/container_page_stream_stats_top.sv -----
// ---------------------------------------------------------------------------
// container_page_stream_stats_top
// Per-stream page statistics: table lookup by serial, saturating update.
// ---------------------------------------------------------------------------
//  channel | handshake          | beat
//  --------+--------------------+-------------------------------------------
//  in      | in_valid/in_stall  | one page descriptor
//  out     | out_valid/out_stall| status, index, packet split, statistics
//
//  From accept to result, the serial memory is scanned one entry per cycle,
//  behind its registered read, until a hit or the last entry in use; then
//  the entry is written back as the result loads into the output register.
//  One descriptor is in work at a time; a finished result waits in the output
//  register while the next descriptor is taken.
//  Reset (rst, synchronous) empties the table; no memory clearing pass.
//  A stalled output holds its beat and holds the write-back of the next one.
// ---------------------------------------------------------------------------
module container_page_stream_stats_top #(
  parameter int MAX_STREAMS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] serial_no,
  input  logic [7:0]  packet_count,
  input  logic [15:0] page_bytes,
  input  logic [15:0] payload_bytes,
  input  logic        first_continues,
  input  logic        last_truncated,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [3:0]  stream_index,
  output logic [7:0]  full_packets,
  output logic [1:0]  partial_packets,
  output logic [31:0] pages_seen,
  output logic [15:0] min_page_bytes,
  output logic [15:0] max_page_bytes,
  output logic [7:0]  min_packets,
  output logic [7:0]  max_packets,
  output logic [31:0] packets_total,
  output logic [47:0] bytes_total,
  output logic [47:0] payload_total
);
  import cpss_pkg::*;

  res_t res;
  res_t res_q;
  logic res_load;
  logic res_free;

  assign res_free = !out_valid || !out_stall;

  cpss_engine #(.MAX_STREAMS(MAX_STREAMS)) u_engine (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .serial_no       (serial_no),
    .packet_count    (packet_count),
    .page_bytes      (page_bytes),
    .payload_bytes   (payload_bytes),
    .first_continues (first_continues),
    .last_truncated  (last_truncated),
    .res_free        (res_free),
    .res_load        (res_load),
    .res             (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) res_q <= res;
  end

  assign status          = res_q.status;
  assign stream_index    = res_q.stream_index;
  assign full_packets    = res_q.full_packets;
  assign partial_packets = res_q.partial_packets;
  assign pages_seen      = res_q.stats.pages;
  assign min_page_bytes  = res_q.stats.min_bytes;
  assign max_page_bytes  = res_q.stats.max_bytes;
  assign min_packets     = res_q.stats.min_packets;
  assign max_packets     = res_q.stats.max_packets;
  assign packets_total   = res_q.stats.packet_sum;
  assign bytes_total     = res_q.stats.byte_sum;
  assign payload_total   = res_q.stats.payload_sum;

endmodule

// ----- rtl/cpss_checker.sv -----
// ---------------------------------------------------------------------------
// cpss_checker
// Port-level checks on the result channel of the stream statistics block.
// ---------------------------------------------------------------------------
module cpss_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  status,
  input logic [3:0]  stream_index,
  input logic [1:0]  partial_packets,
  input logic [31:0] pages_seen,
  input logic [15:0] min_page_bytes,
  input logic [15:0] max_page_bytes,
  input logic [7:0]  min_packets,
  input logic [7:0]  max_packets
);
  import cpss_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(pages_seen))
    else $error("stalled result beat changed");

  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  a_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_FULL |-> stream_index == 4'd0 && pages_seen == 32'd0)
    else $error("table-full beat carries statistics");

  a_order: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_FULL |->
      pages_seen != 32'd0 && min_page_bytes <= max_page_bytes && min_packets <= max_packets)
    else $error("statistics out of order");

  a_part: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> partial_packets != 2'd3 && status != 2'd3)
    else $error("bad partial count or status");

endmodule

bind container_page_stream_stats_top cpss_checker u_cpss_checker (.*);

// ----- tb/sv/container_page_stream_stats_top_tb.sv -----
// ---------------------------------------------------------------------------
// container_page_stream_stats_top_tb
// Drives page descriptors into the stream statistics block and checks every
// result beat against a local per-stream table that tracks the expected
// lookups, allocations, table-full refusals, extremes and saturating sums.
// ---------------------------------------------------------------------------
module container_page_stream_stats_top_tb;
  import cpss_pkg::*;

  localparam int TABLE_DEPTH  = 16;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 2 * (TABLE_DEPTH + 3);
  localparam int HOLD_CYCLES  = 300;

  typedef struct packed {
    logic [31:0] serial;
    logic [7:0]  npk;
    logic [15:0] page_len;
    logic [15:0] body_len;
    logic        cont;
    logic        trunc;
  } page_desc_t;

  typedef struct packed {
    status_t     status;
    logic [3:0]  index;
    logic [7:0]  full;
    logic [1:0]  part;
    logic [31:0] pages;
    logic [15:0] min_len;
    logic [15:0] max_len;
    logic [7:0]  min_pk;
    logic [7:0]  max_pk;
    logic [31:0] pk_sum;
    logic [47:0] len_sum;
    logic [47:0] body_sum;
  } stream_stats_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [31:0] serial_no = '0;
  logic [7:0]  packet_count = '0;
  logic [15:0] page_bytes = '0;
  logic [15:0] payload_bytes = '0;
  logic        first_continues = 1'b0;
  logic        last_truncated = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  status;
  logic [3:0]  stream_index;
  logic [7:0]  full_packets;
  logic [1:0]  partial_packets;
  logic [31:0] pages_seen;
  logic [15:0] min_page_bytes;
  logic [15:0] max_page_bytes;
  logic [7:0]  min_packets;
  logic [7:0]  max_packets;
  logic [31:0] packets_total;
  logic [47:0] bytes_total;
  logic [47:0] payload_total;

  logic [31:0]   tbl_serial [TABLE_DEPTH];
  stream_stats_t tbl_stats [TABLE_DEPTH];
  int            streams_used = 0;
  stream_stats_t expected_stats [$];

  int fail_count    = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_req      = 0;
  int hold_ack      = 0;
  int hold_left     = 0;
  int quiet_cycles  = 0;

  container_page_stream_stats_top #(.MAX_STREAMS(TABLE_DEPTH)) u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .serial_no(serial_no), .packet_count(packet_count),
    .page_bytes(page_bytes), .payload_bytes(payload_bytes),
    .first_continues(first_continues), .last_truncated(last_truncated),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .stream_index(stream_index),
    .full_packets(full_packets), .partial_packets(partial_packets),
    .pages_seen(pages_seen), .min_page_bytes(min_page_bytes),
    .max_page_bytes(max_page_bytes), .min_packets(min_packets),
    .max_packets(max_packets), .packets_total(packets_total),
    .bytes_total(bytes_total), .payload_total(payload_total)
  );

  always #1 clk = ~clk;

  // Stream table update for one accepted descriptor; returns the result beat.
  function automatic stream_stats_t account_page(page_desc_t p);
    stream_stats_t r;
    stream_stats_t e;
    logic [1:0]    edges;
    logic [32:0]   sum33;
    logic [48:0]   sum49;
    int            hit;
    r = '0;
    e = '0;
    hit = -1;
    edges = {1'b0, p.cont} + {1'b0, p.trunc};
    if (p.npk == 8'd1) begin
      if (edges != 2'd0) r.part = 2'd1;
      else r.full = 8'd1;
    end else if (p.npk >= 8'd2) begin
      r.part = edges;
      r.full = p.npk - 8'(edges);
    end
    for (int i = 0; i < streams_used; i++)
      if (hit < 0 && tbl_serial[i] == p.serial) hit = i;
    if (hit >= 0) begin
      r.status = ST_EXISTING;
      e = tbl_stats[hit];
      if (e.max_pk < p.npk) e.max_pk = p.npk;
      if (e.min_pk > p.npk) e.min_pk = p.npk;
      if (e.max_len < p.page_len) e.max_len = p.page_len;
      if (e.min_len > p.page_len) e.min_len = p.page_len;
      if (e.pages != 32'hFFFF_FFFF) e.pages = e.pages + 32'd1;
      sum33 = {1'b0, e.pk_sum} + 33'(p.npk);
      e.pk_sum = sum33[32] ? 32'hFFFF_FFFF : sum33[31:0];
      sum49 = {1'b0, e.len_sum} + 49'(p.page_len);
      e.len_sum = sum49[48] ? 48'hFFFF_FFFF_FFFF : sum49[47:0];
      sum49 = {1'b0, e.body_sum} + 49'(p.body_len);
      e.body_sum = sum49[48] ? 48'hFFFF_FFFF_FFFF : sum49[47:0];
    end else if (streams_used < TABLE_DEPTH) begin
      r.status = ST_NEW;
      hit = streams_used;
      streams_used++;
      tbl_serial[hit] = p.serial;
      e.max_pk   = p.npk;
      e.min_pk   = p.npk;
      e.max_len  = p.page_len;
      e.min_len  = p.page_len;
      e.pages    = 32'd1;
      e.pk_sum   = 32'(p.npk);
      e.len_sum  = 48'(p.page_len);
      e.body_sum = 48'(p.body_len);
    end else begin
      r.status = ST_FULL;
      return r;
    end
    tbl_stats[hit] = e;
    r.index    = 4'(hit);
    r.pages    = e.pages;
    r.min_len  = e.min_len;
    r.max_len  = e.max_len;
    r.min_pk   = e.min_pk;
    r.max_pk   = e.max_pk;
    r.pk_sum   = e.pk_sum;
    r.len_sum  = e.len_sum;
    r.body_sum = e.body_sum;
    return r;
  endfunction

  function automatic page_desc_t page(logic [31:0] serial, logic [7:0] npk,
                                      logic [15:0] page_len, logic [15:0] body_len,
                                      logic cont, logic trunc);
    page_desc_t p;
    p.serial   = serial;
    p.npk      = npk;
    p.page_len = page_len;
    p.body_len = body_len;
    p.cont     = cont;
    p.trunc    = trunc;
    return p;
  endfunction

  // Mostly pages of known streams; about one in ten carries a fresh serial.
  function automatic page_desc_t random_page();
    page_desc_t p;
    if (streams_used > 0 && $urandom_range(99) >= 10)
      p.serial = tbl_serial[$urandom_range(streams_used - 1)];
    else
      p.serial = $urandom;
    case ($urandom_range(7))
      0: p.npk = 8'd0;
      1: p.npk = 8'd1;
      2: p.npk = 8'd2;
      3: p.npk = 8'd255;
      default: p.npk = 8'($urandom_range(255));
    endcase
    case ($urandom_range(7))
      0: p.page_len = 16'd0;
      1: p.page_len = 16'd65307;
      default: p.page_len = 16'($urandom_range(65307));
    endcase
    case ($urandom_range(7))
      0: p.body_len = 16'd0;
      1: p.body_len = 16'd65025;
      default: p.body_len = 16'($urandom_range(65025));
    endcase
    p.cont  = 1'($urandom_range(1));
    p.trunc = 1'($urandom_range(1));
    return p;
  endfunction

  task automatic send_page(page_desc_t p);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    serial_no       <= p.serial;
    packet_count    <= p.npk;
    page_bytes      <= p.page_len;
    payload_bytes   <= p.body_len;
    first_continues <= p.cont;
    last_truncated  <= p.trunc;
    do @(posedge clk); while (in_stall);
    expected_stats.insert(expected_stats.size(), account_page(p));
  endtask

  task automatic send_random_pages(int count);
    repeat (count) send_page(random_page());
  endtask

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      fail_count++;
      if (fail_count <= 10)
        $display("mismatch %s: expected %0h, got %0h", name, want, got);
    end
  endfunction

  // result beat checker
  always @(posedge clk) begin
    stream_stats_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_stats.size() == 0) begin
        fail_count++;
        if (fail_count <= 10) $display("mismatch: result beat with nothing expected");
      end else begin
        want = expected_stats.pop_front();
        check_field("status", 64'(want.status), 64'(status));
        check_field("stream_index", 64'(want.index), 64'(stream_index));
        check_field("full_packets", 64'(want.full), 64'(full_packets));
        check_field("partial_packets", 64'(want.part), 64'(partial_packets));
        check_field("pages_seen", 64'(want.pages), 64'(pages_seen));
        check_field("min_page_bytes", 64'(want.min_len), 64'(min_page_bytes));
        check_field("max_page_bytes", 64'(want.max_len), 64'(max_page_bytes));
        check_field("min_packets", 64'(want.min_pk), 64'(min_packets));
        check_field("max_packets", 64'(want.max_pk), 64'(max_packets));
        check_field("packets_total", 64'(want.pk_sum), 64'(packets_total));
        check_field("bytes_total", 64'(want.len_sum), 64'(bytes_total));
        check_field("payload_total", 64'(want.body_sum), 64'(payload_total));
      end
    end
  end

  // output stall: long hold-off when requested, else random
  always @(posedge clk) begin
    if (hold_req != hold_ack) begin
      hold_ack  <= hold_req;
      out_stall <= 1'b1;
      hold_left <= HOLD_CYCLES - 1;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("timeout: no beat moved for %0d cycles", STALL_LIMIT);
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic test_packet_split_and_extremes();
    send_page(page(32'h0000_0000, 8'd0, 16'd0, 16'd0, 1'b0, 1'b0));
    send_page(page(32'h0000_0000, 8'd255, 16'd65307, 16'd65025, 1'b0, 1'b0));
    send_page(page(32'hFFFF_FFFF, 8'd1, 16'd100, 16'd50, 1'b0, 1'b0));
    send_page(page(32'hFFFF_FFFF, 8'd1, 16'd200, 16'd150, 1'b1, 1'b0));
    send_page(page(32'hFFFF_FFFF, 8'd1, 16'd27, 16'd0, 1'b0, 1'b1));
    send_page(page(32'hFFFF_FFFF, 8'd1, 16'd4096, 16'd4069, 1'b1, 1'b1));
    send_page(page(32'h0000_0000, 8'd2, 16'd300, 16'd270, 1'b1, 1'b1));
    send_page(page(32'h0000_0000, 8'd2, 16'd301, 16'd271, 1'b1, 1'b0));
    send_page(page(32'h0000_0000, 8'd255, 16'd65307, 16'd65025, 1'b1, 1'b1));
    send_page(page(32'h0000_0000, 8'd0, 16'd27, 16'd0, 1'b1, 1'b1));
    send_page(page(32'hA5A5_5A5A, 8'd128, 16'd32768, 16'd32767, 1'b0, 1'b1));
    send_page(page(32'hA5A5_5A5A, 8'd10, 16'd1, 16'd65025, 1'b1, 1'b0));
    send_page(page(32'hFFFF_FFFF, 8'd0, 16'd65307, 16'd0, 1'b0, 1'b0));
  endtask

  task automatic test_stream_allocation();
    send_random_pages(250);
  endtask

  task automatic test_table_full();
    while (streams_used < TABLE_DEPTH)
      send_page(page($urandom, 8'($urandom_range(255)), 16'($urandom_range(65307)),
                     16'($urandom_range(65025)), 1'b0, 1'b1));
    send_page(page(32'h5A5A_A5A5, 8'd0, 16'd0, 16'd0, 1'b0, 1'b0));
    send_page(page($urandom, 8'd1, 16'd500, 16'd400, 1'b1, 1'b0));
    send_page(page($urandom, 8'd1, 16'd500, 16'd400, 1'b0, 1'b0));
    send_page(page($urandom, 8'd2, 16'd900, 16'd800, 1'b1, 1'b1));
    send_page(page($urandom, 8'd255, 16'd65307, 16'd65025, 1'b0, 1'b1));
    send_page(page(tbl_serial[0], 8'd7, 16'd1200, 16'd1100, 1'b0, 1'b0));
    send_page(page(tbl_serial[TABLE_DEPTH - 1], 8'd3, 16'd60, 16'd33, 1'b1, 1'b1));
  endtask

  // receiver holds off while the sender keeps offering; the block backs up
  task automatic test_output_hold_off();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req++;
    send_random_pages(12);
  endtask

  task automatic test_random_traffic();
    send_idle_pct = 51;
    recv_idle_pct = 22;
    send_random_pages(240);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_random_pages(240);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    send_idle_pct = 22;
    recv_idle_pct = 51;
    test_packet_split_and_extremes();
    test_stream_allocation();
    test_table_full();
    test_random_traffic();
    test_output_hold_off();
    in_valid <= 1'b0;
    while (expected_stats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
